// ===== rtl/mrs_pkg.sv =====
// Shared constants, types and the CRC-16 step for the Modbus RTU register slave.
`default_nettype none
package mrs_pkg;

	// Register bank geometry and request limits.
	localparam int NUM_REGS      = 256;
	localparam int MAX_READ_REGS = 29;
	localparam int REG_W         = 16;
	localparam int REG_AW        = $clog2(NUM_REGS);
	localparam int CNT_W         = $clog2(MAX_READ_REGS + 1);

	// Register indexes up to this one reset to their own index, the rest to zero.
	localparam int RST_MAX_IDX = 'h000A;

	// Station address after reset.
	localparam logic [7:0] SLAVE_ADDR_RST = 8'h02;

	// Function codes.
	localparam logic [7:0] FN_READ  = 8'h03;
	localparam logic [7:0] FN_WRITE = 8'h06;

	// Frame capture.
	localparam int HDR_DEPTH = 8;
	localparam int HDR_AW    = $clog2(HDR_DEPTH);

	// CRC-16 constants (reflected polynomial).
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Command queue between the front and the back.
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	// One checked request, ready to be carried out.
	typedef struct packed {
		logic        is_write;
		logic [7:0]  station;
		logic [15:0] addr;
		logic [15:0] val;
	} cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One byte through the CRC-16 register, LSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/mrs_if.sv =====
// Valid/ready channel interfaces for received and transmitted bytes.
`default_nettype none
interface mrs_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrs_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;

	modport source (output valid, output tx_byte, output last, input ready);
	modport sink (input valid, input tx_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/mrs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mrs_front.sv =====
// Receive side: CRC accumulation, header capture and frame classification.
`default_nettype none
module mrs_front import mrs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mrs_rx_if.sink          rx,
	input  wire logic [7:0] slave_addr,
	input  wire q_stat_t    q_stat,
	output logic            push,
	output cmd_t            cmd
);

	logic [7:0]  cnt_q;
	logic [15:0] crc_q;
	logic [7:0]  hdr_q [HDR_DEPTH];

	logic        accept;
	logic [15:0] crc_next;
	logic [7:0]  hdr_v [6];
	logic [7:0]  fn;
	logic [15:0] addr;
	logic [15:0] val;
	logic        rd_ok;
	logic        wr_ok;
	logic        frame_ok;

	assign rx.ready = !q_stat.full;
	assign accept   = rx.valid && rx.ready;

	// The header as it stands once the current byte is taken in.
	always_comb begin
		crc_next = crc16_byte(crc_q, rx.rx_byte);
		for (int k = 0; k < 6; k++) begin
			hdr_v[k] = (cnt_q == 8'(k)) ? rx.rx_byte : hdr_q[k];
		end
	end

	assign fn   = hdr_v[1];
	assign addr = {hdr_v[2], hdr_v[3]};
	assign val  = {hdr_v[4], hdr_v[5]};

	// Range checks for the two supported functions.
	always_comb begin
		rd_ok = (fn == FN_READ) && (val != 16'd0) && (32'(val) <= 32'(MAX_READ_REGS))
			&& ((17'(addr) + 17'(val)) <= 17'(NUM_REGS));
		wr_ok = (fn == FN_WRITE) && (17'(addr) < 17'(NUM_REGS));
		frame_ok = (cnt_q >= 8'd3) && (crc_next == 16'd0) && (hdr_v[0] != 8'd0)
			&& (hdr_v[0] == slave_addr) && (rd_ok || wr_ok);
	end

	assign push = accept && rx.frame_end && frame_ok;

	always_comb begin
		cmd.is_write = wr_ok;
		cmd.station  = hdr_v[0];
		cmd.addr     = addr;
		cmd.val      = val;
	end

	// Byte counter and running CRC, restarted after each frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 8'd0;
			crc_q <= CRC_INIT;
		end else if (accept) begin
			if (rx.frame_end) begin
				cnt_q <= 8'd0;
				crc_q <= CRC_INIT;
			end else begin
				if (cnt_q != 8'hFF) begin
					cnt_q <= cnt_q + 8'd1;
				end
				crc_q <= crc_next;
			end
		end
	end

	// The first bytes of a frame are kept; later frames overwrite only what they carry.
	always_ff @(posedge clk) begin
		if (accept && (cnt_q < 8'(HDR_DEPTH))) begin
			hdr_q[cnt_q[HDR_AW-1:0]] <= rx.rx_byte;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mrs_cmd_fifo.sv =====
// Short command queue between the receive front and the response back.
`default_nettype none
module mrs_cmd_fifo import mrs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wr_cmd,
	input  wire logic pop,
	output cmd_t      rd_cmd,
	output q_stat_t   status
);

	cmd_t               ent_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;

	assign status.full  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_cmd       = ent_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_cmd;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full && !pop))
		else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("command queue read while empty");
`endif

endmodule
`default_nettype wire

// ===== rtl/mrs_back.sv =====
// Response side: register bank access and response byte sequencing with CRC.
`default_nettype none
module mrs_back import mrs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_t    head,
	input  wire q_stat_t q_stat,
	output logic         pop,
	mrs_tx_if.source     tx
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR  = 3'd1;
	localparam logic [2:0] ST_DHI  = 3'd2;
	localparam logic [2:0] ST_DLO  = 3'd3;
	localparam logic [2:0] ST_CLO  = 3'd4;
	localparam logic [2:0] ST_CHI  = 3'd5;

	localparam logic [2:0] HDR_LAST_RD = 3'd2;
	localparam logic [2:0] HDR_LAST_WR = 3'd5;

	logic [2:0]        state_q;
	cmd_t              cmd_q;
	logic [2:0]        hidx_q;
	logic [CNT_W-1:0]  ridx_q;
	logic [REG_AW-1:0] rd_ptr_q;
	logic [15:0]       crc_tx_q;
	logic              ov_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic [NUM_REGS-1:0] vld_q;
	logic                vld_rd_q;
	logic [REG_AW-1:0]   rd_addr_q;

	logic              adv;
	logic              ram_we;
	logic              ram_re;
	logic [REG_AW-1:0] ram_raddr;
	logic [REG_W-1:0]  ram_rdata;
	logic [REG_W-1:0]  reg_val;
	logic [7:0]        hdr_byte;
	logic [7:0]        em_byte;
	logic              em_valid;
	logic              em_last;
	logic              em_crc;
	logic [CNT_W-1:0]  rcount;

	assign tx.valid   = ov_q;
	assign tx.tx_byte = byte_q;
	assign tx.last    = last_q;

	assign adv    = !ov_q || tx.ready;
	assign pop    = (state_q == ST_IDLE) && !q_stat.empty;
	assign rcount = cmd_q.val[CNT_W-1:0];

	// A write is carried out as its command leaves the queue.
	assign ram_we = pop && head.is_write;

	// Register reads: the first at the start, the next after each low data byte.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q;
		if (pop) begin
			ram_re    = !head.is_write;
			ram_raddr = head.addr[REG_AW-1:0];
		end else if ((state_q == ST_DLO) && adv && (ridx_q != rcount - 1'b1)) begin
			ram_re = 1'b1;
		end
	end

	mrs_ram #(
		.WIDTH (REG_W),
		.DEPTH (NUM_REGS)
	) u_bank (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head.addr[REG_AW-1:0]),
		.wdata (head.val),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entries never written read as their reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[head.addr[REG_AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			vld_rd_q  <= vld_q[ram_raddr];
			rd_addr_q <= ram_raddr;
		end
	end

	always_comb begin
		if (vld_rd_q) begin
			reg_val = ram_rdata;
		end else if (32'(rd_addr_q) <= 32'(RST_MAX_IDX)) begin
			reg_val = REG_W'(rd_addr_q);
		end else begin
			reg_val = '0;
		end
	end

	// Fixed response header bytes.
	always_comb begin
		case (hidx_q)
			3'd0:    hdr_byte = cmd_q.station;
			3'd1:    hdr_byte = cmd_q.is_write ? FN_WRITE : FN_READ;
			3'd2:    hdr_byte = cmd_q.is_write ? cmd_q.addr[15:8] : {cmd_q.val[6:0], 1'b0};
			3'd3:    hdr_byte = cmd_q.addr[7:0];
			3'd4:    hdr_byte = cmd_q.val[15:8];
			3'd5:    hdr_byte = cmd_q.val[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	// Byte chosen in the current state.
	always_comb begin
		em_valid = 1'b1;
		em_last  = 1'b0;
		em_crc   = 1'b1;
		case (state_q)
			ST_HDR: em_byte = hdr_byte;
			ST_DHI: em_byte = reg_val[15:8];
			ST_DLO: em_byte = reg_val[7:0];
			ST_CLO: begin
				em_byte = crc_tx_q[7:0];
				em_crc  = 1'b0;
			end
			ST_CHI: begin
				em_byte = crc_tx_q[15:8];
				em_crc  = 1'b0;
				em_last = 1'b1;
			end
			default: begin
				em_byte  = 8'h00;
				em_valid = 1'b0;
				em_crc   = 1'b0;
			end
		endcase
	end

	// Response sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			hidx_q   <= 3'd0;
			ridx_q   <= '0;
			rd_ptr_q <= '0;
			crc_tx_q <= CRC_INIT;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q  <= ST_HDR;
						hidx_q   <= 3'd0;
						ridx_q   <= '0;
						rd_ptr_q <= head.addr[REG_AW-1:0] + 1'b1;
						crc_tx_q <= CRC_INIT;
					end
				end
				ST_HDR: begin
					if (adv) begin
						hidx_q <= hidx_q + 3'd1;
						if (hidx_q == (cmd_q.is_write ? HDR_LAST_WR : HDR_LAST_RD)) begin
							state_q <= cmd_q.is_write ? ST_CLO : ST_DHI;
						end
					end
				end
				ST_DHI: begin
					if (adv) begin
						state_q <= ST_DLO;
					end
				end
				ST_DLO: begin
					if (adv) begin
						ridx_q <= ridx_q + 1'b1;
						if (ridx_q == rcount - 1'b1) begin
							state_q <= ST_CLO;
						end else begin
							state_q  <= ST_DHI;
							rd_ptr_q <= rd_ptr_q + 1'b1;
						end
					end
				end
				ST_CLO: begin
					if (adv) begin
						state_q <= ST_CHI;
					end
				end
				ST_CHI: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (adv && em_crc) begin
				crc_tx_q <= crc16_byte(crc_tx_q, em_byte);
			end
		end
	end

	// Command being answered.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
	end

	// Output register: loads whenever the previous byte is gone or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= em_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= em_byte;
			last_q <= em_last;
		end
	end

`ifndef SYNTHESIS
	a_last_after_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHI && adv) |=> (tx.valid && tx.last))
		else $error("final CRC byte not presented with last");
	a_data_only_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DHI || state_q == ST_DLO) |-> !cmd_q.is_write)
		else $error("register data phase entered for a write");
`endif

endmodule
`default_nettype wire

// ===== rtl/modbus_rtu_register_slave.sv =====
// Top level: one request per received byte; a checked frame queues a command, the back answers.
// Input: one byte request per cycle while the two-entry command queue has room.
// Path: a checked frame queues its command; the sequencer pops it when idle and starts the reply.
// Output: one response byte per cycle unless the sink stalls, paced by the sequencer and one
// registered bank read per register; replies run 8 bytes for a write, 5 + 2 x count for a read.
// Reset: asynchronous and active low; the bank reads as its reset contents at once (valid bits).
`default_nettype none
module modbus_rtu_register_slave import mrs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mrs_rx_if.sink          rx,
	mrs_tx_if.source        tx,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	logic [7:0] slave_addr_q;
	logic       push;
	logic       pop;
	cmd_t       wr_cmd;
	cmd_t       rd_cmd;
	q_stat_t    q_stat;

	// Station address register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= SLAVE_ADDR_RST;
		end else if (cfg_we) begin
			slave_addr_q <= cfg_wdata;
		end
	end

	mrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.slave_addr (slave_addr_q),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (wr_cmd)
	);

	mrs_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.status (q_stat)
	);

	mrs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (rd_cmd),
		.q_stat (q_stat),
		.pop    (pop),
		.tx     (tx)
	);

endmodule
`default_nettype wire

// ===== verif/modbus_rtu_register_slave_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU register slave: random frames against a bit-exact model.
module modbus_rtu_register_slave_tb;
	import mrs_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int TAIL_CYCLES   = 40;

	typedef enum logic [1:0] {IT_BYTE, IT_DRAIN, IT_CFG} rx_op_e;

	typedef struct {
		rx_op_e     op;
		logic [7:0] data;
		logic       fin;
		logic       hold;
	} rx_item_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} tx_beat_t;

	// Clock, reset and the signals driven into the block.
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       drv_valid  = 1'b0;
	logic [7:0] drv_byte   = '0;
	logic       drv_end    = 1'b0;
	logic       sink_ready = 1'b0;
	logic       cfg_we     = 1'b0;
	logic [7:0] cfg_wdata  = '0;
	logic       hold_go    = 1'b0;
	logic       calm       = 1'b0;
	int         hold_left  = 0;

	mrs_rx_if rx_ch();
	mrs_tx_if tx_ch();

	assign rx_ch.valid     = drv_valid;
	assign rx_ch.rx_byte   = drv_byte;
	assign rx_ch.frame_end = drv_end;
	assign tx_ch.ready     = sink_ready;

	modbus_rtu_register_slave u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.tx        (tx_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the slave state.
	logic [15:0] model_bank [NUM_REGS];
	logic [7:0]  model_hdr [HDR_DEPTH];
	logic [7:0]  model_count;
	logic [15:0] model_crc;
	logic [7:0]  model_station;

	rx_item_t   rx_backlog[$];
	tx_beat_t   reply_bytes[$];
	logic [7:0] frame_buf[$];
	logic [7:0] plan_station;

	int errors        = 0;
	int items_built   = 0;
	int frames_built  = 0;
	int replies_due   = 0;
	int bytes_taken   = 0;
	int bytes_checked = 0;
	int settings_used = 1;

	// Driver bookkeeping.
	int       send_gap;
	int       quiet_cycles;
	logic     offer;
	logic     we_next;
	logic     hold_next;
	logic     cur_hold;
	rx_item_t nxt;

	// Receiver bookkeeping.
	int       take_stall;
	tx_beat_t want;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bit-serial CRC-16, reflected, one data bit per shift.
	function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[15:1]};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic model_reset();
		for (int i = 0; i < NUM_REGS; i++) begin
			model_bank[i] = (i <= RST_MAX_IDX) ? 16'(i) : 16'h0000;
		end
		foreach (model_hdr[k]) begin
			model_hdr[k] = 8'h00;
		end
		model_count   = '0;
		model_crc     = CRC_INIT;
		model_station = SLAVE_ADDR_RST;
	endtask

	// Appends the response CRC and files every byte as an expected beat.
	task automatic queue_response(input logic [7:0] body[$]);
		logic [15:0] c;
		tx_beat_t    beat;
		c = CRC_INIT;
		beat.last = 1'b0;
		foreach (body[k]) begin
			c = crc_next(c, body[k]);
			beat.data = body[k];
			reply_bytes.push_back(beat);
		end
		beat.data = c[7:0];
		reply_bytes.push_back(beat);
		beat.data = c[15:8];
		beat.last = 1'b1;
		reply_bytes.push_back(beat);
		replies_due++;
	endtask

	// Advances the shadow slave by one received byte and predicts any response.
	task automatic modbus_track_byte(input logic [7:0] b, input logic fin);
		int          n;
		int          a;
		int          c;
		logic [15:0] crc;
		logic [15:0] r;
		logic [7:0]  body[$];
		if (model_count < HDR_DEPTH) begin
			model_hdr[model_count[HDR_AW-1:0]] = b;
		end
		if (model_count != 8'hFF) begin
			model_count = model_count + 8'd1;
		end
		model_crc = crc_next(model_crc, b);
		if (!fin) begin
			return;
		end
		n = model_count;
		crc = model_crc;
		model_count = '0;
		model_crc = CRC_INIT;
		if (n < 4 || crc != 16'h0000) begin
			return;
		end
		if (model_hdr[0] == 8'h00 || model_hdr[0] != model_station) begin
			return;
		end
		a = {model_hdr[2], model_hdr[3]};
		c = {model_hdr[4], model_hdr[5]};
		if (model_hdr[1] == FN_READ) begin
			if (c == 0 || c > MAX_READ_REGS || a + c > NUM_REGS) begin
				return;
			end
			body.push_back(model_station);
			body.push_back(FN_READ);
			body.push_back(8'(c * 2));
			for (int j = 0; j < c; j++) begin
				r = model_bank[a + j];
				body.push_back(r[15:8]);
				body.push_back(r[7:0]);
			end
			queue_response(body);
		end else if (model_hdr[1] == FN_WRITE) begin
			if (a >= NUM_REGS) begin
				return;
			end
			model_bank[a] = 16'(c);
			body.push_back(model_station);
			body.push_back(FN_WRITE);
			body.push_back(model_hdr[2]);
			body.push_back(model_hdr[3]);
			body.push_back(model_hdr[4]);
			body.push_back(model_hdr[5]);
			queue_response(body);
		end
	endtask

	// Frame construction.
	task automatic put(input logic [7:0] b);
		frame_buf.push_back(b);
	endtask

	task automatic queue_bytes(input bit hold);
		rx_item_t it;
		foreach (frame_buf[k]) begin
			it.op   = IT_BYTE;
			it.data = frame_buf[k];
			it.fin  = (k == frame_buf.size() - 1);
			it.hold = hold && (k == 0);
			rx_backlog.push_back(it);
		end
		items_built += frame_buf.size();
		frames_built++;
		frame_buf.delete();
	endtask

	task automatic seal_frame(input bit corrupt, input bit hold);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (frame_buf[k]) begin
			c = crc_next(c, frame_buf[k]);
		end
		if (corrupt) begin
			c = c ^ 16'($urandom_range(1, 16'hFFFF));
		end
		put(c[7:0]);
		put(c[15:8]);
		queue_bytes(hold);
	endtask

	task automatic queue_ctl(input rx_op_e op, input logic [7:0] d);
		rx_item_t it;
		it.op   = op;
		it.data = d;
		it.fin  = 1'b0;
		it.hold = 1'b0;
		rx_backlog.push_back(it);
	endtask

	task automatic plan_req(input logic [7:0] st, fn, input logic [15:0] a, v);
		frame_buf.delete();
		put(st);
		put(fn);
		put(a[15:8]);
		put(a[7:0]);
		put(v[15:8]);
		put(v[7:0]);
	endtask

	// Legal read: mostly short runs, now and then up to the limit, often at the bank edges.
	task automatic plan_good_read();
		int c;
		int a;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			c = $urandom_range(1, 4);
		end else if (pick < 9) begin
			c = $urandom_range(5, 15);
		end else begin
			c = $urandom_range(16, MAX_READ_REGS);
		end
		case ($urandom_range(0, 3))
			0: a = 0;
			1: a = NUM_REGS - c;
			default: a = $urandom_range(0, NUM_REGS - c);
		endcase
		plan_req(plan_station, FN_READ, 16'(a), 16'(c));
	endtask

	// Legal write, biased toward the low registers so that reads see the new values.
	task automatic plan_good_write();
		int          a;
		logic [15:0] v;
		case ($urandom_range(0, 5))
			0, 1: a = $urandom_range(0, 15);
			2: a = NUM_REGS - 1;
			default: a = $urandom_range(0, NUM_REGS - 1);
		endcase
		case ($urandom_range(0, 5))
			0: v = 16'hFFFF;
			1: v = 16'h0000;
			default: v = 16'($urandom);
		endcase
		plan_req(plan_station, FN_WRITE, 16'(a), v);
	endtask

	task automatic rand_frame();
		int         pick;
		int         c;
		int         a;
		int         n;
		logic [7:0] st;
		logic [7:0] fn;
		pick = $urandom_range(0, 99);
		if (pick < 34) begin
			plan_good_read();
			seal_frame(1'b0, 1'b0);
		end else if (pick < 58) begin
			plan_good_write();
			seal_frame(1'b0, 1'b0);
		end else if (pick < 62) begin
			// Read with a zero count, a count over the limit, or a run past the bank.
			case ($urandom_range(0, 2))
				0: begin
					c = 0;
					a = $urandom_range(0, NUM_REGS - 1);
				end
				1: begin
					c = $urandom_range(MAX_READ_REGS + 1, 16'hFFFF);
					a = $urandom_range(0, 15);
				end
				default: begin
					c = $urandom_range(1, MAX_READ_REGS);
					a = $urandom_range(NUM_REGS - c + 1, 16'hFFFF);
				end
			endcase
			plan_req(plan_station, FN_READ, 16'(a), 16'(c));
			seal_frame(1'b0, 1'b0);
		end else if (pick < 65) begin
			// Write beyond the bank.
			plan_req(plan_station, FN_WRITE, 16'($urandom_range(NUM_REGS, 16'hFFFF)),
				16'($urandom));
			seal_frame(1'b0, 1'b0);
		end else if (pick < 70) begin
			// Good request with a damaged CRC.
			if ($urandom_range(0, 1)) begin
				plan_good_read();
			end else begin
				plan_good_write();
			end
			seal_frame(1'b1, 1'b0);
		end else if (pick < 74) begin
			// Broadcast or some other station.
			do begin
				st = 8'($urandom_range(0, 255));
			end while (st == plan_station);
			if ($urandom_range(0, 1)) begin
				st = 8'h00;
			end
			plan_good_read();
			frame_buf[0] = st;
			seal_frame(1'b0, 1'b0);
		end else if (pick < 77) begin
			// Unsupported function code.
			do begin
				fn = 8'($urandom);
			end while (fn == FN_READ || fn == FN_WRITE);
			plan_good_write();
			frame_buf[1] = fn;
			seal_frame(1'b0, 1'b0);
		end else if (pick < 81) begin
			// Short frame: one byte with its CRC, or one to three loose bytes.
			frame_buf.delete();
			if ($urandom_range(0, 1)) begin
				put(plan_station);
				seal_frame(1'b0, 1'b0);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) put(8'($urandom));
				queue_bytes(1'b0);
			end
		end else if (pick < 86) begin
			// Four to seven bytes: the header bytes not sent come from earlier frames.
			frame_buf.delete();
			put(plan_station);
			put($urandom_range(0, 1) ? FN_READ : FN_WRITE);
			n = $urandom_range(0, 3);
			repeat (n) put(8'($urandom));
			seal_frame(1'b0, 1'b0);
		end else if (pick < 90) begin
			// Longer than the header: the trailing bytes only feed the CRC.
			if ($urandom_range(0, 1)) begin
				plan_good_read();
			end else begin
				plan_good_write();
			end
			n = $urandom_range(1, 8);
			repeat (n) put(8'($urandom));
			seal_frame(1'b0, 1'b0);
		end else begin
			// Line noise.
			frame_buf.delete();
			n = $urandom_range(1, 12);
			repeat (n) put(8'($urandom));
			queue_bytes(1'b0);
		end
	endtask

	// Request driver: random gaps, drains before settings change, register writes when idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_byte <= '0;
			drv_end <= 1'b0;
			cfg_we <= 1'b0;
			cfg_wdata <= '0;
			hold_go <= 1'b0;
			calm <= 1'b0;
			send_gap = 0;
			quiet_cycles = 0;
			cur_hold = 1'b0;
		end else begin
			hold_next = 1'b0;
			we_next = 1'b0;
			offer = drv_valid;
			if (drv_valid && rx_ch.ready) begin
				modbus_track_byte(drv_byte, drv_end);
				bytes_taken++;
				hold_next = cur_hold;
				offer = 1'b0;
				send_gap = calm ? 0 : $urandom_range(0, 4);
			end
			if (reply_bytes.size() == 0 && !drv_valid) begin
				quiet_cycles++;
			end else begin
				quiet_cycles = 0;
			end
			if (!offer) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (rx_backlog.size() != 0) begin
					nxt = rx_backlog[0];
					if (nxt.op == IT_BYTE) begin
						void'(rx_backlog.pop_front());
						drv_byte <= nxt.data;
						drv_end <= nxt.fin;
						cur_hold = nxt.hold;
						offer = 1'b1;
					end else if (quiet_cycles >= SETTLE_CYCLES) begin
						// The block is idle: nothing pending and any silent frame has settled.
						void'(rx_backlog.pop_front());
						quiet_cycles = 0;
						if (nxt.op == IT_CFG) begin
							we_next = 1'b1;
							cfg_wdata <= nxt.data;
							model_station = nxt.data;
							settings_used++;
						end
					end
				end
			end
			drv_valid <= offer;
			cfg_we <= we_next;
			hold_go <= hold_next;
			calm <= bytes_taken[6];
		end
	end

	// Long receiver hold-off, started by a marked request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Response monitor: random stalls, each accepted byte compared with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			take_stall = 0;
		end else begin
			if (tx_ch.valid && sink_ready) begin
				bytes_checked++;
				if (reply_bytes.size() == 0) begin
					$display("%0t: unexpected response byte, expected none, actual %02h last %b",
						$time, tx_ch.tx_byte, tx_ch.last);
					errors++;
				end else begin
					want = reply_bytes.pop_front();
					if (tx_ch.tx_byte !== want.data) begin
						$display("%0t: tx_byte expected %02h, actual %02h",
							$time, want.data, tx_ch.tx_byte);
						errors++;
					end
					if (tx_ch.last !== want.last) begin
						$display("%0t: last expected %b, actual %b", $time, want.last, tx_ch.last);
						errors++;
					end
				end
				take_stall = calm ? 0 : $urandom_range(0, 4);
			end else if (take_stall != 0) begin
				take_stall--;
			end
			sink_ready <= (take_stall == 0) && (hold_left == 0);
		end
	end

	// Stimulus plan, reset and end of run.
	initial begin
		logic [7:0] stations [6];
		int         quota [6];
		int         target;
		model_reset();
		plan_station = SLAVE_ADDR_RST;

		// Directed: widest read of the reset contents, write at the bank top with all ones,
		// a three-byte frame, and a four-byte write that reuses the stored header.
		plan_req(plan_station, FN_READ, 16'h0000, 16'(MAX_READ_REGS));
		seal_frame(1'b0, 1'b0);
		plan_req(plan_station, FN_WRITE, 16'(NUM_REGS - 1), 16'hFFFF);
		seal_frame(1'b0, 1'b0);
		frame_buf.delete();
		put(plan_station);
		seal_frame(1'b0, 1'b0);
		frame_buf.delete();
		put(plan_station);
		put(FN_WRITE);
		seal_frame(1'b0, 1'b0);

		// Random phases, each under its own station address.
		stations = '{8'd1, 8'd247, 8'($urandom_range(3, 246)), 8'd0,
			8'($urandom_range(3, 246)), SLAVE_ADDR_RST};
		quota = '{30, 90, 15, 15, 25, 25};
		foreach (stations[p]) begin
			plan_station = stations[p];
			queue_ctl(IT_CFG, plan_station);
			if (p == 2) begin
				// One frame long enough to saturate the byte counter, then a full drain.
				plan_good_read();
				repeat (252) put(8'($urandom));
				seal_frame(1'b0, 1'b0);
				queue_ctl(IT_DRAIN, 8'h00);
			end
			target = items_built + quota[p];
			if (p == 1) begin
				// The receiver holds off while good requests keep coming.
				plan_good_read();
				seal_frame(1'b0, 1'b1);
				repeat (9) begin
					if ($urandom_range(0, 1)) begin
						plan_good_read();
					end else begin
						plan_good_write();
					end
					seal_frame(1'b0, 1'b0);
				end
			end
			while (items_built < target) begin
				rand_frame();
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(posedge clk);
		end while (rx_backlog.size() != 0 || drv_valid || reply_bytes.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d request bytes in %0d frames over %0d station settings.",
			bytes_taken, frames_built, settings_used);
		$display("Checked %0d response bytes from %0d predicted replies.",
			bytes_checked, replies_due);
		if (errors == 0) begin
			$display("modbus_rtu_register_slave_tb: PASS");
		end else begin
			$display("modbus_rtu_register_slave_tb: FAIL");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#8ms;
		$display("modbus_rtu_register_slave_tb: FAIL");
		$finish;
	end

endmodule
